### design/ptgs_pkg.sv
// ----------------------------------------------------------------------------
// Pointer to game coordinate scaler package
// Shared widths, reset values, register indexes and the configuration record.
// ----------------------------------------------------------------------------
package ptgs_pkg;

    localparam int COORD_W = 12;
    localparam int CELL_W  = 7;
    localparam int OFS_W   = 12;
    localparam int EXT_W   = 13;
    localparam int POS_W   = 21;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int DEF_OUT_WIDTH  = 320;
    localparam int DEF_OUT_HEIGHT = 200;

    localparam logic [CELL_W-1:0] RST_CELL_WIDTH  = 7'd8;
    localparam logic [CELL_W-1:0] RST_CELL_HEIGHT = 7'd16;
    localparam logic [OFS_W-1:0]  RST_VIEW_LEFT   = 12'd0;
    localparam logic [OFS_W-1:0]  RST_VIEW_TOP    = 12'd0;
    localparam logic [EXT_W-1:0]  RST_VIEW_WIDTH  = 13'd640;
    localparam logic [EXT_W-1:0]  RST_VIEW_HEIGHT = 13'd400;

    typedef enum logic [2:0] {
        REG_PIXEL_UNITS = 3'd0,
        REG_CELL_WIDTH  = 3'd1,
        REG_CELL_HEIGHT = 3'd2,
        REG_VIEW_LEFT   = 3'd3,
        REG_VIEW_TOP    = 3'd4,
        REG_VIEW_WIDTH  = 3'd5,
        REG_VIEW_HEIGHT = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic              pixel_units;
        logic [CELL_W-1:0] cell_width;
        logic [CELL_W-1:0] cell_height;
        logic [OFS_W-1:0]  view_left;
        logic [OFS_W-1:0]  view_top;
        logic [EXT_W-1:0]  view_width;
        logic [EXT_W-1:0]  view_height;
    } t_cfg;

endpackage

### design/ptgs_front.sv
// ----------------------------------------------------------------------------
// Pointer to game coordinate scaler front end
// Three stages: pixel position, viewport clamp and offset, scaling product.
// ----------------------------------------------------------------------------
module ptgs_front #(
    parameter int OUT_WIDTH  = ptgs_pkg::DEF_OUT_WIDTH,
    parameter int OUT_HEIGHT = ptgs_pkg::DEF_OUT_HEIGHT,
    parameter int NUM_W      = 25
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ptgs_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ptgs_pkg::COORD_W-1:0] i_column,
    input  logic [ptgs_pkg::COORD_W-1:0] i_line,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [NUM_W-1:0]             o_num_x,
    output logic [NUM_W-1:0]             o_num_y
);
    import ptgs_pkg::*;

    function automatic logic signed [POS_W-1:0] f_pos(
        input logic [COORD_W-1:0] coord,
        input logic [CELL_W-1:0]  cell_sz,
        input logic               pm
    );
        logic signed [COORD_W:0] c;
        logic signed [POS_W-1:0] prod;
        logic signed [POS_W-1:0] half;
        c    = $signed({1'b0, coord} - {{COORD_W{1'b0}}, 1'b1});
        prod = POS_W'(c) * $signed(POS_W'({1'b0, cell_sz}));
        half = $signed(POS_W'({1'b0, cell_sz[CELL_W-1:1]}));
        f_pos = pm ? POS_W'(c) : prod + half;
    endfunction

    function automatic logic [EXT_W-1:0] f_offset(
        input logic signed [POS_W-1:0] pos,
        input logic [OFS_W-1:0]        lo,
        input logic [EXT_W-1:0]        ext
    );
        logic signed [POS_W:0] p;
        logic signed [POS_W:0] l;
        logic signed [POS_W:0] h;
        p = (POS_W+1)'(pos);
        l = $signed((POS_W+1)'(lo));
        h = l + $signed((POS_W+1)'(ext)) - $signed((POS_W+1)'(1));
        if (ext == '0) begin
            f_offset = '0;
        end else if (p < l) begin
            f_offset = '0;
        end else if (p > h) begin
            f_offset = ext - 1'b1;
        end else begin
            f_offset = EXT_W'(p - l);
        end
    endfunction

    logic                    r_v1, r_v2, r_v3;
    logic                    rdy1, rdy2, rdy3;
    logic signed [POS_W-1:0] r_px, r_py;
    logic [EXT_W-1:0]        r_dx, r_dy;
    logic [NUM_W-1:0]        r_nx, r_ny;
    logic signed [POS_W-1:0] n_px, n_py;
    logic [EXT_W-1:0]        n_dx, n_dy;
    logic [NUM_W-1:0]        n_nx, n_ny;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_num_x = r_nx;
    assign o_num_y = r_ny;

    always_comb begin
        n_px = f_pos(i_column, i_cfg.cell_width, i_cfg.pixel_units);
        n_py = f_pos(i_line, i_cfg.cell_height, i_cfg.pixel_units);
        n_dx = f_offset(r_px, i_cfg.view_left, i_cfg.view_width);
        n_dy = f_offset(r_py, i_cfg.view_top, i_cfg.view_height);
        n_nx = NUM_W'(r_dx) * NUM_W'(OUT_WIDTH);
        n_ny = NUM_W'(r_dy) * NUM_W'(OUT_HEIGHT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_px <= n_px;
            r_py <= n_py;
        end
        if (rdy2 && r_v1) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (rdy3 && r_v2) begin
            r_nx <= n_nx;
            r_ny <= n_ny;
        end
    end

endmodule

### design/ptgs_cell.sv
// ----------------------------------------------------------------------------
// Pointer to game coordinate scaler divider cell
// One restoring division step for each axis, registered, with its own handshake.
// ----------------------------------------------------------------------------
module ptgs_cell #(
    parameter int NQ = 9
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    output logic                       o_valid,
    input  logic                       i_ready,
    input  logic [ptgs_pkg::EXT_W-1:0] i_div_x,
    input  logic [ptgs_pkg::EXT_W-1:0] i_div_y,
    input  logic [ptgs_pkg::EXT_W-1:0] i_rem_x,
    input  logic [ptgs_pkg::EXT_W-1:0] i_rem_y,
    input  logic [NQ-1:0]              i_num_x,
    input  logic [NQ-1:0]              i_num_y,
    input  logic [NQ-1:0]              i_quo_x,
    input  logic [NQ-1:0]              i_quo_y,
    output logic [ptgs_pkg::EXT_W-1:0] o_rem_x,
    output logic [ptgs_pkg::EXT_W-1:0] o_rem_y,
    output logic [NQ-1:0]              o_num_x,
    output logic [NQ-1:0]              o_num_y,
    output logic [NQ-1:0]              o_quo_x,
    output logic [NQ-1:0]              o_quo_y
);
    import ptgs_pkg::*;

    logic             r_valid;
    logic [EXT_W-1:0] r_rem_x, r_rem_y;
    logic [NQ-1:0]    r_num_x, r_num_y, r_quo_x, r_quo_y;
    logic [EXT_W:0]   trial_x, trial_y;
    logic             ge_x, ge_y;
    logic [EXT_W-1:0] n_rem_x, n_rem_y;
    logic [NQ-1:0]    n_num_x, n_num_y, n_quo_x, n_quo_y;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_num_x = r_num_x;
    assign o_num_y = r_num_y;
    assign o_quo_x = r_quo_x;
    assign o_quo_y = r_quo_y;

    always_comb begin
        trial_x = {i_rem_x, i_num_x[NQ-1]};
        trial_y = {i_rem_y, i_num_y[NQ-1]};
        ge_x    = trial_x >= {1'b0, i_div_x};
        ge_y    = trial_y >= {1'b0, i_div_y};
        n_rem_x = ge_x ? EXT_W'(trial_x - {1'b0, i_div_x}) : EXT_W'(trial_x);
        n_rem_y = ge_y ? EXT_W'(trial_y - {1'b0, i_div_y}) : EXT_W'(trial_y);
        n_num_x = i_num_x << 1;
        n_num_y = i_num_y << 1;
        n_quo_x = NQ'({i_quo_x, ge_x});
        n_quo_y = NQ'({i_quo_y, ge_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_num_x <= n_num_x;
            r_num_y <= n_num_y;
            r_quo_x <= n_quo_x;
            r_quo_y <= n_quo_y;
        end
    end

endmodule

### design/pointer_to_game_coordinate_scaler.sv
// ----------------------------------------------------------------------------
// Pointer to game coordinate scaler
// Maps a one-based terminal mouse report onto game screen coordinates.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle while no stage is stalled;
// each result passes the front stages and then NQ divider cells, where NQ
// is the bit width of the larger output coordinate. Three front stages form
// the pixel position, clamp it into the viewport and multiply by the screen
// span; a row of NQ divider cells then produces one quotient bit each. Every
// stage holds its item until the next one is free, so a stalled output does
// not stop earlier stages from filling. The user must write configuration
// through the APB port only while no item is in flight; it is not enforced.
module pointer_to_game_coordinate_scaler #(
    parameter int OUT_WIDTH  = ptgs_pkg::DEF_OUT_WIDTH,
    parameter int OUT_HEIGHT = ptgs_pkg::DEF_OUT_HEIGHT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptgs_pkg::ADDR_W-1:0]  paddr,
    input  logic [ptgs_pkg::DATA_W-1:0]  pwdata,
    output logic [ptgs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ptgs_pkg::COORD_W-1:0] i_column,
    input  logic [ptgs_pkg::COORD_W-1:0] i_line,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [$clog2(OUT_WIDTH)-1:0]  o_game_x,
    output logic [$clog2(OUT_HEIGHT)-1:0] o_game_y
);
    import ptgs_pkg::*;

    localparam int XW    = $clog2(OUT_WIDTH);
    localparam int YW    = $clog2(OUT_HEIGHT);
    localparam int NQ    = (XW > YW) ? XW : YW;
    localparam int SPMAX = (OUT_WIDTH > OUT_HEIGHT) ? OUT_WIDTH : OUT_HEIGHT;
    localparam int NUM_W = EXT_W + $clog2(SPMAX + 1);

    t_cfg             r_cfg;
    t_reg_idx         reg_idx;
    logic             cfg_wr;
    logic [EXT_W-1:0] div_x, div_y;
    logic [NUM_W-1:0] num_x, num_y;

    logic             s_valid [NQ+1];
    logic             s_ready [NQ+1];
    logic [EXT_W-1:0] s_rem_x [NQ+1];
    logic [EXT_W-1:0] s_rem_y [NQ+1];
    logic [NQ-1:0]    s_num_x [NQ+1];
    logic [NQ-1:0]    s_num_y [NQ+1];
    logic [NQ-1:0]    s_quo_x [NQ+1];
    logic [NQ-1:0]    s_quo_y [NQ+1];

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_units <= 1'b0;
            r_cfg.cell_width  <= RST_CELL_WIDTH;
            r_cfg.cell_height <= RST_CELL_HEIGHT;
            r_cfg.view_left   <= RST_VIEW_LEFT;
            r_cfg.view_top    <= RST_VIEW_TOP;
            r_cfg.view_width  <= RST_VIEW_WIDTH;
            r_cfg.view_height <= RST_VIEW_HEIGHT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PIXEL_UNITS: r_cfg.pixel_units <= pwdata[0];
                REG_CELL_WIDTH:  r_cfg.cell_width  <= pwdata[CELL_W-1:0];
                REG_CELL_HEIGHT: r_cfg.cell_height <= pwdata[CELL_W-1:0];
                REG_VIEW_LEFT:   r_cfg.view_left   <= pwdata[OFS_W-1:0];
                REG_VIEW_TOP:    r_cfg.view_top    <= pwdata[OFS_W-1:0];
                REG_VIEW_WIDTH:  r_cfg.view_width  <= pwdata[EXT_W-1:0];
                REG_VIEW_HEIGHT: r_cfg.view_height <= pwdata[EXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PIXEL_UNITS: prdata = DATA_W'(r_cfg.pixel_units);
            REG_CELL_WIDTH:  prdata = DATA_W'(r_cfg.cell_width);
            REG_CELL_HEIGHT: prdata = DATA_W'(r_cfg.cell_height);
            REG_VIEW_LEFT:   prdata = DATA_W'(r_cfg.view_left);
            REG_VIEW_TOP:    prdata = DATA_W'(r_cfg.view_top);
            REG_VIEW_WIDTH:  prdata = DATA_W'(r_cfg.view_width);
            REG_VIEW_HEIGHT: prdata = DATA_W'(r_cfg.view_height);
            default:         prdata = '0;
        endcase
    end

    // A zero extent gives a zero product, so an all-ones divisor yields zero.
    assign div_x = (r_cfg.view_width == '0) ? '1 : r_cfg.view_width;
    assign div_y = (r_cfg.view_height == '0) ? '1 : r_cfg.view_height;

    ptgs_front #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT),
        .NUM_W      (NUM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_column (i_column),
        .i_line   (i_line),
        .o_valid  (s_valid[0]),
        .i_ready  (s_ready[0]),
        .o_num_x  (num_x),
        .o_num_y  (num_y)
    );

    assign s_rem_x[0] = EXT_W'(num_x >> NQ);
    assign s_rem_y[0] = EXT_W'(num_y >> NQ);
    assign s_num_x[0] = num_x[NQ-1:0];
    assign s_num_y[0] = num_y[NQ-1:0];
    assign s_quo_x[0] = '0;
    assign s_quo_y[0] = '0;

    for (genvar k = 0; k < NQ; k++) begin : g_cell
        ptgs_cell #(
            .NQ (NQ)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .i_div_x (div_x),
            .i_div_y (div_y),
            .i_rem_x (s_rem_x[k]),
            .i_rem_y (s_rem_y[k]),
            .i_num_x (s_num_x[k]),
            .i_num_y (s_num_y[k]),
            .i_quo_x (s_quo_x[k]),
            .i_quo_y (s_quo_y[k]),
            .o_rem_x (s_rem_x[k+1]),
            .o_rem_y (s_rem_y[k+1]),
            .o_num_x (s_num_x[k+1]),
            .o_num_y (s_num_y[k+1]),
            .o_quo_x (s_quo_x[k+1]),
            .o_quo_y (s_quo_y[k+1])
        );
    end

    assign s_ready[NQ] = i_ready;
    assign o_valid     = s_valid[NQ];
    assign o_game_x    = XW'(s_quo_x[NQ]);
    assign o_game_y    = YW'(s_quo_y[NQ]);

`ifndef SYNTHESIS
    a_x_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(s_quo_x[NQ]) < OUT_WIDTH))
        else $error("Horizontal quotient beyond the screen width.");

    a_y_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(s_quo_y[NQ]) < OUT_HEIGHT))
        else $error("Vertical quotient beyond the screen height.");

    a_x_zero_ext : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cfg.view_width == '0) |-> (s_quo_x[NQ] == '0))
        else $error("Zero viewport width did not give a zero coordinate.");

    a_y_zero_ext : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cfg.view_height == '0) |-> (s_quo_y[NQ] == '0))
        else $error("Zero viewport height did not give a zero coordinate.");
`endif

endmodule
